[rtl/srp_pkg.sv]
// Shared types, character codes and the default message table for the reply parser.
package srp_pkg;

   localparam int TEXT_BYTES_DEF = 256;
   localparam int MSG_LEN = 19;

   localparam logic OP_RX = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam logic [15:0] CODE_MIN = 16'd100;
   localparam logic [19:0] CODE_MAX = 20'd65535;

   typedef enum logic [1:0] {
      KIND_COMPLETE = 2'd0,
      KIND_READ = 2'd1,
      KIND_NONE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_SPACE
   } state_type;

   typedef struct packed {
      kind_type kind;
      logic [15:0] code;
      logic [7:0] len;
      logic use_mem;
      logic [7:0] byte_val;
   } res_type;

   function automatic logic [7:0] msg_char(input logic [4:0] i);
      logic [7:0] c;
      case (i)
         5'd0: c = "N";
         5'd1: c = "o";
         5'd2: c = " ";
         5'd3: c = "r";
         5'd4: c = "e";
         5'd5: c = "p";
         5'd6: c = "l";
         5'd7: c = "y";
         5'd8: c = " ";
         5'd9: c = "t";
         5'd10: c = "e";
         5'd11: c = "x";
         5'd12: c = "t";
         5'd13: c = " ";
         5'd14: c = "g";
         5'd15: c = "i";
         5'd16: c = "v";
         5'd17: c = "e";
         5'd18: c = "n";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[rtl/srp_text_store.sv]
// Reply text memory with one write port and one registered read port.
module srp_text_store import srp_pkg::*; #(
   parameter int TEXT_BYTES = TEXT_BYTES_DEF,
   parameter int AW = $clog2(TEXT_BYTES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [TEXT_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/srp_parse.sv]
// Line parser and reply sequencer that issues text store writes and reads.
module srp_parse import srp_pkg::*; #(
   parameter int TEXT_BYTES = TEXT_BYTES_DEF,
   parameter int AW = $clog2(TEXT_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_accept,
   input  logic          req_operation,
   input  logic [7:0]    req_rx_byte,
   input  logic [7:0]    req_read_index,
   output logic          busy,
   output logic          res_valid,
   output res_type       res,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr
);

   localparam int LW = (AW > 8) ? AW : 8;
   localparam int DEF_LEN = (MSG_LEN < TEXT_BYTES - 1) ? MSG_LEN : TEXT_BYTES - 1;

   typedef struct packed {
      logic [15:0]   code;
      logic [2:0]    pos;
      logic          digit;
      logic          codeend;
      logic          dash;
      logic          skip;
      logic          cr;
      logic [AW-1:0] wr;
      logic [AW-1:0] cnt;
   } ln_type;

   ln_type        ln_ff, ln_in;
   logic [15:0]   held_ff, held_in;
   logic          in_cont_ff, in_cont_in;
   logic [AW-1:0] text_len_ff, text_len_in;
   logic          reply_held_ff, reply_held_in;
   logic          use_def_ff, use_def_in;
   state_type     st_ff, st_in;
   logic [7:0]    pend_byte_ff, pend_byte_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic          need_feed, need_space;

   function automatic ln_type content_f(input ln_type s, input logic [7:0] x,
                                        output logic put, output logic [AW-1:0] addr);
      ln_type r;
      logic is_dig;
      logic go;
      logic [2:0] p;
      logic [19:0] prod;
      logic blank;
      r = s;
      put = 1'b0;
      addr = s.wr;
      is_dig = (x >= CH_ZERO) && (x <= CH_NINE);
      blank = (x == CH_SPACE) || ((x >= CH_TAB) && (x <= CH_CR));
      go = 1'b1;
      prod = 20'(s.code) * 20'd10 + 20'(x - CH_ZERO);
      if (s.cnt < AW'(TEXT_BYTES - 2)) begin
         r.cnt = s.cnt + AW'(1);
         if (!s.digit) begin
            if (!is_dig) begin
               go = 1'b0;
            end else begin
               r.digit = 1'b1;
               r.pos = 3'd0;
            end
         end
         if (go) begin
            p = r.pos;
            if (r.pos < 3'd4) begin
               r.pos = r.pos + 3'd1;
            end
            if (!r.codeend) begin
               if (is_dig) begin
                  r.code = (prod > CODE_MAX) ? 16'hFFFF : prod[15:0];
               end else begin
                  r.codeend = 1'b1;
               end
            end
            if (p == 3'd3 && x == CH_DASH) begin
               r.dash = 1'b1;
               r.skip = 1'b1;
            end else if (p >= 3'd3) begin
               if (!(r.skip && blank)) begin
                  r.skip = 1'b0;
                  if (r.wr < AW'(TEXT_BYTES - 1)) begin
                     put = 1'b1;
                     r.wr = r.wr + AW'(1);
                  end
               end
            end
         end
      end
      return r;
   endfunction

   always_comb begin
      logic put;
      logic [AW-1:0] paddr;
      logic [AW-1:0] w;
      logic done;
      logic [LW-1:0] idx_ext;
      logic [LW-1:0] len_ext;
      ln_in = ln_ff;
      held_in = held_ff;
      in_cont_in = in_cont_ff;
      text_len_in = text_len_ff;
      reply_held_in = reply_held_ff;
      use_def_in = use_def_ff;
      pend_byte_in = pend_byte_ff;
      pend_addr_in = pend_addr_ff;
      need_feed = 1'b0;
      need_space = 1'b0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = req_rx_byte;
      rd_en = 1'b0;
      res_valid = 1'b0;
      res = '0;
      put = 1'b0;
      paddr = '0;
      w = '0;
      done = 1'b0;
      idx_ext = LW'(req_read_index);
      len_ext = LW'(text_len_ff);
      rd_addr = idx_ext[AW-1:0];
      unique case (st_ff)
         ST_FEED: begin
            ln_in = content_f(ln_ff, pend_byte_ff, put, paddr);
            wr_en = put;
            wr_addr = paddr;
            wr_data = pend_byte_ff;
         end
         ST_SPACE: begin
            wr_en = 1'b1;
            wr_addr = pend_addr_ff;
            wr_data = CH_SPACE;
         end
         default: begin
            if (req_accept && req_operation == OP_READ) begin
               res_valid = 1'b1;
               if (!reply_held_ff) begin
                  res.kind = KIND_NONE;
               end else begin
                  res.kind = KIND_READ;
                  res.code = held_ff;
                  res.len = len_ext[7:0];
                  if (idx_ext < len_ext) begin
                     if (use_def_ff && idx_ext < LW'(DEF_LEN)) begin
                        res.byte_val = msg_char(idx_ext[4:0]);
                     end else begin
                        res.use_mem = 1'b1;
                        rd_en = 1'b1;
                     end
                  end
               end
            end else if (req_accept) begin
               if (reply_held_ff) begin
                  reply_held_in = 1'b0;
                  text_len_in = '0;
                  ln_in.wr = '0;
                  use_def_in = 1'b0;
               end
               if (req_rx_byte == CH_LF) begin
                  if (in_cont_in) begin
                     if (ln_in.code == held_in && !ln_in.dash) begin
                        text_len_in = ln_in.wr;
                        in_cont_in = 1'b0;
                        done = 1'b1;
                     end
                  end else begin
                     held_in = ln_in.code;
                     w = ln_in.wr;
                     if (w == '0) begin
                        use_def_in = 1'b1;
                        w = AW'(DEF_LEN);
                     end
                     if (ln_in.dash) begin
                        in_cont_in = 1'b1;
                        if (w < AW'(TEXT_BYTES - 4)) begin
                           wr_en = 1'b1;
                           wr_addr = w;
                           wr_data = CH_SEMI;
                           need_space = 1'b1;
                           pend_addr_in = w + AW'(1);
                           w = w + AW'(2);
                        end
                     end else begin
                        done = 1'b1;
                     end
                     text_len_in = w;
                  end
                  if (done && held_in < CODE_MIN) begin
                     text_len_in = '0;
                     use_def_in = 1'b0;
                     in_cont_in = 1'b0;
                     done = 1'b0;
                  end
                  ln_in = '0;
                  ln_in.wr = text_len_in;
                  if (done) begin
                     reply_held_in = 1'b1;
                     res_valid = 1'b1;
                     res.kind = KIND_COMPLETE;
                     res.code = held_in;
                     res.len = 8'(text_len_in);
                  end
               end else begin
                  if (ln_in.cr) begin
                     ln_in.cr = 1'b0;
                     ln_in = content_f(ln_in, CH_CR, put, paddr);
                     wr_en = put;
                     wr_addr = paddr;
                     wr_data = CH_CR;
                     if (req_rx_byte == CH_CR) begin
                        ln_in.cr = 1'b1;
                     end else begin
                        need_feed = 1'b1;
                        pend_byte_in = req_rx_byte;
                     end
                  end else if (req_rx_byte == CH_CR) begin
                     ln_in.cr = 1'b1;
                  end else begin
                     ln_in = content_f(ln_in, req_rx_byte, put, paddr);
                     wr_en = put;
                     wr_addr = paddr;
                     wr_data = req_rx_byte;
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      st_in = ST_IDLE;
      unique case (st_ff)
         ST_IDLE: begin
            if (need_feed) begin
               st_in = ST_FEED;
            end else if (need_space) begin
               st_in = ST_SPACE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      unique case (st_ff)
         ST_IDLE: busy = 1'b0;
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ln_ff <= '0;
         held_ff <= '0;
         in_cont_ff <= 1'b0;
         text_len_ff <= '0;
         reply_held_ff <= 1'b0;
         use_def_ff <= 1'b0;
         st_ff <= ST_IDLE;
      end else begin
         ln_ff <= ln_in;
         held_ff <= held_in;
         in_cont_ff <= in_cont_in;
         text_len_ff <= text_len_in;
         reply_held_ff <= reply_held_in;
         use_def_ff <= use_def_in;
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      pend_addr_ff <= pend_addr_in;
   end

endmodule

[rtl/smtp_reply_parser.sv]
// Top level of the reply parser: parser, text memory, result stage and output register.
// A result beat is registered in the result stage and then in the output register.
// Throughput: one request beat per cycle unless the parser is busy or the result stage stalls;
// a byte other than CR or LF that follows a held CR, and a continuation first line that writes
// the separator, add a busy write state because the text memory has a single write port.
// Reset clears parser state except the pending byte and address, and empties both result regs.
module smtp_reply_parser import srp_pkg::*; #(
   parameter int TEXT_BYTES = TEXT_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_reply_code,
   output logic [7:0]  rsp_text_length,
   output logic [7:0]  rsp_text_byte
);

   localparam int AW = $clog2(TEXT_BYTES);

   logic          accept;
   logic          busy;
   logic          res_valid;
   res_type       res;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          s1_adv;

   logic          s1_valid_ff, s1_valid_in;
   res_type       s1_res_ff, s1_res_in;
   logic          out_valid_ff, out_valid_in;
   res_type       out_res_ff, out_res_in;

   assign s1_adv = !out_valid_ff || rsp_ready;
   assign req_ready = !busy && (!s1_valid_ff || s1_adv);
   assign accept = req_valid && req_ready;

   srp_parse #(.TEXT_BYTES(TEXT_BYTES), .AW(AW)) u_parse (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (accept),
      .req_operation  (req_operation),
      .req_rx_byte    (req_rx_byte),
      .req_read_index (req_read_index),
      .busy           (busy),
      .res_valid      (res_valid),
      .res            (res),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr)
   );

   srp_text_store #(.TEXT_BYTES(TEXT_BYTES), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_res_in = s1_res_ff;
      out_valid_in = out_valid_ff;
      out_res_in = out_res_ff;
      if (accept) begin
         s1_valid_in = res_valid;
         s1_res_in = res;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (s1_valid_ff && s1_adv) begin
         out_valid_in = 1'b1;
         out_res_in = s1_res_ff;
         if (s1_res_ff.use_mem) begin
            out_res_in.byte_val = rd_data;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_res_ff <= s1_res_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result_kind = out_res_ff.kind;
   assign rsp_reply_code = out_res_ff.code;
   assign rsp_text_length = out_res_ff.len;
   assign rsp_text_byte = out_res_ff.byte_val;

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("Text memory written and read in the same cycle.");

   a_busy_blocks_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && wr_en && res_valid) |-> 1'b0)
      else $error("A beat with a result also wrote the text memory.");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_res_ff)))
      else $error("Stalled result stage lost its beat.");

   a_complete_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_COMPLETE) |-> (rsp_reply_code >= CODE_MIN))
      else $error("Completed reply reported with a code below 100.");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the SMTP reply parser: random replies, reads and handshake stalls.
module tb_top;
   import srp_pkg::*;

   localparam int TEXT_BYTES = TEXT_BYTES_DEF;
   localparam int DEFAULT_LEN = MSG_LEN;
   localparam logic [8*DEFAULT_LEN-1:0] NO_TEXT_MSG = "No reply text given";
   localparam int TARGET_ITEMS = 650;
   localparam int TAIL_ITEMS = 60;
   localparam int HOLD_AFTER = 24;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int LIMIT_CYCLES = 200000;
   localparam int MAX_PRINTS = 100;

   typedef struct {
      logic       op;
      logic [7:0] rx_byte;
      logic [7:0] read_idx;
   } parser_req_type;

   typedef struct {
      kind_type    kind;
      logic [15:0] code;
      logic [7:0]  length;
      logic [7:0]  text;
   } reply_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OP_RX;
   logic [7:0]  req_rx_byte = '0;
   logic [7:0]  req_read_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_reply_code;
   logic [7:0]  rsp_text_length;
   logic [7:0]  rsp_text_byte;

   parser_req_type   req_backlog[$];
   parser_req_type   next_req;
   reply_result_type reply_results[$];
   reply_result_type due_now;

   int   fail_count = 0;
   int   results_seen = 0;
   int   send_gap = 0;
   int   send_calm = 0;
   int   stall_left = 0;
   int   recv_calm = 0;
   logic tail_phase = 1'b0;
   logic long_hold_done = 1'b0;

   // Parser state as the predictor tracks it.
   logic [7:0]  stored_text [0:TEXT_BYTES-1];
   logic [8:0]  stored_len = '0;
   logic [8:0]  wr_ptr = '0;
   logic [8:0]  line_count = '0;
   logic [15:0] held_code = '0;
   logic [15:0] cur_code = '0;
   logic [7:0]  cur_pos = '0;
   logic        awaiting_last = 1'b0;
   logic        reply_held = 1'b0;
   logic        default_text = 1'b0;
   logic        seen_digit = 1'b0;
   logic        code_done = 1'b0;
   logic        saw_dash = 1'b0;
   logic        skip_blank = 1'b0;
   logic        cr_pending = 1'b0;

   smtp_reply_parser u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_rx_byte     (req_rx_byte),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_reply_code  (rsp_reply_code),
      .rsp_text_length (rsp_text_length),
      .rsp_text_byte   (rsp_text_byte)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void parse_line_byte(input logic [7:0] c);
      logic        is_digit;
      logic [7:0]  pos;
      int unsigned acc;
      is_digit = c >= CH_ZERO && c <= CH_NINE;
      if (!seen_digit) begin
         if (!is_digit) return;
         seen_digit = 1'b1;
         cur_pos = '0;
      end
      pos = cur_pos;
      if (cur_pos != 8'd255) cur_pos = cur_pos + 8'd1;
      if (!code_done) begin
         if (is_digit) begin
            acc = 32'(cur_code) * 32'd10 + 32'(c) - 32'(CH_ZERO);
            cur_code = (acc > CODE_MAX) ? CODE_MAX[15:0] : acc[15:0];
         end else begin
            code_done = 1'b1;
         end
      end
      if (pos < 8'd3) return;
      if (pos == 8'd3 && c == CH_DASH) begin
         saw_dash = 1'b1;
         skip_blank = 1'b1;
         return;
      end
      if (skip_blank) begin
         if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
         skip_blank = 1'b0;
      end
      if (wr_ptr < TEXT_BYTES - 1) begin
         stored_text[wr_ptr[7:0]] = c;
         wr_ptr = wr_ptr + 9'd1;
      end
   endfunction

   function automatic void count_line_byte(input logic [7:0] c);
      if (line_count >= TEXT_BYTES - 2) return;
      line_count = line_count + 9'd1;
      parse_line_byte(c);
   endfunction

   function automatic logic close_line();
      logic done;
      done = 1'b0;
      if (awaiting_last) begin
         if (cur_code == held_code && !saw_dash) begin
            stored_len = wr_ptr;
            awaiting_last = 1'b0;
            done = 1'b1;
         end
      end else begin
         held_code = cur_code;
         if (wr_ptr == 0) begin
            default_text = 1'b1;
            wr_ptr = 9'(DEFAULT_LEN);
         end
         if (saw_dash) begin
            awaiting_last = 1'b1;
            if (wr_ptr < TEXT_BYTES - 4) begin
               stored_text[wr_ptr[7:0]] = CH_SEMI;
               stored_text[wr_ptr[7:0] + 8'd1] = CH_SPACE;
               wr_ptr = wr_ptr + 9'd2;
            end
         end else begin
            done = 1'b1;
         end
         stored_len = wr_ptr;
      end
      cur_code = '0;
      cur_pos = '0;
      line_count = '0;
      {seen_digit, code_done, saw_dash, skip_blank, cr_pending} = '0;
      if (done && held_code < CODE_MIN) begin
         stored_len = '0;
         default_text = 1'b0;
         awaiting_last = 1'b0;
         done = 1'b0;
      end
      wr_ptr = stored_len;
      if (done) reply_held = 1'b1;
      return done;
   endfunction

   function automatic void track_reply(input logic op, input logic [7:0] b,
                                       input logic [7:0] idx);
      reply_result_type r;
      int               k;
      r.kind = KIND_COMPLETE;
      r.code = '0;
      r.length = '0;
      r.text = '0;
      if (op == OP_READ) begin
         if (reply_held) begin
            r.kind = KIND_READ;
            r.code = held_code;
            r.length = stored_len[7:0];
            if (idx >= stored_len) begin
               r.text = '0;
            end else if (default_text && idx < DEFAULT_LEN) begin
               k = DEFAULT_LEN - 1 - int'(idx);
               r.text = NO_TEXT_MSG[8*k +: 8];
            end else begin
               r.text = stored_text[idx];
            end
         end else begin
            r.kind = KIND_NONE;
         end
         reply_results.push_back(r);
         return;
      end
      if (reply_held) begin
         reply_held = 1'b0;
         stored_len = '0;
         wr_ptr = '0;
         default_text = 1'b0;
      end
      if (b == CH_LF) begin
         if (close_line()) begin
            r.code = held_code;
            r.length = stored_len[7:0];
            reply_results.push_back(r);
         end
         return;
      end
      if (cr_pending) begin
         cr_pending = 1'b0;
         count_line_byte(CH_CR);
      end
      if (b == CH_CR) cr_pending = 1'b1;
      else count_line_byte(b);
   endfunction

   task automatic report(input string what, input int got, input int want);
      if (fail_count < MAX_PRINTS) $display("mismatch: %s got %0d want %0d", what, got, want);
      fail_count++;
   endtask

   function automatic void push_rx(input logic [7:0] b);
      parser_req_type r;
      r.op = OP_RX;
      r.rx_byte = b;
      r.read_idx = 8'($urandom_range(0, 255));
      req_backlog.push_back(r);
   endfunction

   function automatic void push_read(input logic [7:0] idx);
      parser_req_type r;
      r.op = OP_READ;
      r.rx_byte = 8'($urandom_range(0, 255));
      r.read_idx = idx;
      req_backlog.push_back(r);
   endfunction

   function automatic void push_str(input string s);
      int i;
      for (i = 0; i < s.len(); i++) push_rx(s[i]);
   endfunction

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(32, 126));
      if (c == CH_LF) c = CH_SEMI;
      return c;
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_LF) c = "#";
      return c;
   endfunction

   function automatic void push_eol();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) push_rx(CH_CR);
      if (r == 0) push_rx(CH_CR);
      push_rx(CH_LF);
   endfunction

   function automatic void push_line(input string code_txt, input logic dash, input int n_text);
      int i;
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) push_rx(noise_char());
      for (i = 0; i < code_txt.len(); i++) push_rx(code_txt[i]);
      if (dash) begin
         push_rx(CH_DASH);
         if ($urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 2)) push_rx($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      end else if (n_text > 0 && $urandom_range(0, 7) != 0) begin
         push_rx(CH_SPACE);
      end
      repeat (n_text) push_rx(text_char());
      push_eol();
   endfunction

   function automatic void build_reply();
      string code_txt;
      string other_txt;
      int    sel;
      logic  dash;
      sel = $urandom_range(0, 9);
      if (sel == 0) code_txt = $sformatf("%0d", $urandom_range(0, 99));
      else if (sel == 1)
         code_txt = $sformatf("%0d%0d", $urandom_range(100000, 999999), $urandom_range(0, 9));
      else if (sel == 2) code_txt = $sformatf("%0d", $urandom_range(0, 65535));
      else code_txt = $sformatf("%0d", $urandom_range(100, 599));
      other_txt = $sformatf("%0d", $urandom_range(100, 599));
      dash = $urandom_range(0, 9) < 6;
      push_line(code_txt, dash, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12));
      if (dash) begin
         repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 7) == 0) push_read(8'($urandom_range(0, 255)));
            push_line(($urandom_range(0, 3) == 0) ? other_txt : code_txt, 1'b1,
                      $urandom_range(0, 8));
         end
         push_line(($urandom_range(0, 9) == 0) ? other_txt : code_txt, 1'b0,
                   $urandom_range(0, 12));
      end
      repeat ($urandom_range(0, 4))
         push_read(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 40)));
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 6))
            push_rx(($urandom_range(0, 2) == 0) ? CH_LF : text_char());
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) track_reply(req_operation, req_rx_byte, req_read_index);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (req_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               next_req = req_backlog.pop_front();
               req_operation <= next_req.op;
               req_rx_byte <= next_req.rx_byte;
               req_read_index <= next_req.read_idx;
               req_valid <= 1'b1;
               if (req_backlog.size() < TAIL_ITEMS) tail_phase <= 1'b1;
               else if (send_calm > 0) send_calm = send_calm - 1;
               else if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(20, 60);
               else if ($urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 8);
            end
         end
      end
   end

   // The receiver holds off once for a long stretch so that the parser backs up and
   // stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
         long_hold_done = 1'b1;
         stall_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (recv_calm > 0) begin
         recv_calm = recv_calm - 1;
         rsp_ready <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(20, 60);
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (reply_results.size() == 0) begin
            report("beat with nothing due, kind", rsp_result_kind, -1);
         end else begin
            due_now = reply_results.pop_front();
            if (rsp_result_kind !== due_now.kind)
               report("result kind", rsp_result_kind, due_now.kind);
            if (rsp_reply_code !== due_now.code)
               report("reply code", rsp_reply_code, due_now.code);
            if (rsp_text_length !== due_now.length)
               report("text length", rsp_text_length, due_now.length);
            if (rsp_text_byte !== due_now.text)
               report("text byte", rsp_text_byte, due_now.text);
         end
      end
   end

   initial begin
      push_read(8'hFF);
      push_str("99");
      push_rx(CH_LF);
      push_str("500");
      push_rx(CH_CR);
      push_rx(CH_LF);
      push_read(8'd0);
      push_read(8'd18);
      push_read(8'd19);
      push_read(8'hFF);
      push_str("x");
      push_rx(CH_CR);
      push_str("y");
      push_rx(CH_LF);
      push_read(8'd0);
      push_str("99999");
      push_rx(8'h00);
      push_rx(8'hFF);
      push_rx(CH_LF);
      push_read(8'd2);
      push_read(8'd3);
      // A first line past the line cap and a last line that runs the text store full.
      push_line("224", 1'b1, 258);
      push_line("224", 1'b0, 12);
      push_read(8'd0);
      push_read(8'd250);
      push_read(8'd253);
      push_read(8'd254);
      push_read(8'd255);
      while (req_backlog.size() < TARGET_ITEMS) build_reply();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (reply_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("smtp_reply_parser regression: pass");
      else $display("smtp_reply_parser regression: fail");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 20);
      $display("smtp_reply_parser regression: fail");
      $finish;
   end

endmodule
